// ===== sv/fdrq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fdrq_pkg;

  // Item actions
  localparam logic [1:0] ACT_REP_REPORT   = 2'd0;
  localparam logic [1:0] ACT_DET_REPORT   = 2'd1;
  localparam logic [1:0] ACT_DET_SETTINGS = 2'd2;
  localparam logic [1:0] ACT_REP_START    = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_CONFIRM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_LIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_CONFIRM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_CONFIRM  = 2'd3;

  localparam logic [15:0] RST_REP_CONFIRM  = 16'd1;
  localparam logic [7:0]  RST_OFFLINE_LIM  = 8'd3;
  localparam logic [7:0]  RST_REAL_CONFIRM = 8'd3;
  localparam logic [7:0]  RST_PRE_CONFIRM  = 8'd3;

  // Detector limits per type
  localparam logic [7:0] SMOKE_MIN      = 8'd7;
  localparam logic [7:0] HEAT_MIN       = 8'd40;
  localparam logic [7:0] SMOKE_PRE_DEF  = 8'd8;
  localparam logic [7:0] SMOKE_REAL_DEF = 8'd12;
  localparam logic [7:0] HEAT_PRE_DEF   = 8'd60;
  localparam logic [7:0] HEAT_REAL_DEF  = 8'd80;
  localparam logic [7:0] SMOKE_MAX      = 8'd22;
  localparam logic [7:0] HEAT_MAX       = 8'd120;
  localparam logic [7:0] SILENT_VALUE   = 8'd255;

  localparam logic [15:0] STATUS_MASK = 16'h7FFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  repeater_addr;
    logic [15:0] repeater_data;
    logic [7:0]  detector_addr;
    logic [7:0]  detector_data;
    logic [7:0]  pre_threshold;
    logic [7:0]  real_threshold;
    logic        smoke_type;
    logic        comm_stop;
    logic [15:0] start_address;
  } req_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic        index_valid;
    logic        pre_fire;
    logic        real_fire;
    logic        led_on;
    logic        offline;
  } rsp_t;

  typedef struct packed {
    logic [7:0] reading;
    logic [7:0] pre_limit;
    logic [7:0] real_limit;
    logic [7:0] pre_hits;
    logic [7:0] real_hits;
    logic [7:0] silent_hits;
    logic       smoke;
    logic       stop;
    logic       offline;
    logic       real_fire;
    logic       pre_fire;
    logic       led;
  } det_entry_t;

  typedef struct packed {
    logic [15:0] status;
    logic [15:0] change_hits;
    logic [15:0] first_slot;
  } rep_entry_t;

  typedef struct packed {
    logic [7:0] offline_limit;
    logic [7:0] real_fire_confirm;
    logic [7:0] pre_fire_confirm;
  } det_cfg_t;

endpackage

`default_nettype wire

// ===== sv/fire_detector_report_qualifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                              Moves
// req       req_valid / req_ready / req          one report or table write per transaction
// rsp       rsp_valid / rsp_ready / rsp          one qualified result per transaction
// cfg       cfg_wr_en / cfg_index / cfg_wr_data  register write, no wait, no read-back
//
// Repeater items read the repeater table, then write it back; detector items read the
// detector table after the repeater table, since the repeater table read yields the detector
// index before the detector table can be read. One transaction is in flight at a time.
// After reset a clearing pass zeroes both tables, one address per step across the deeper
// table, with req_ready low. Configuration writes are taken throughout.
// The result register lets the next transaction enter while a result waits; write-back
// holds while rsp is stalled.

module fire_detector_report_qualifier #(
  parameter int DETECTORS  = 256,
  parameter int REPEATERS  = 64,
  parameter int INDEX_BASE = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  fdrq_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output fdrq_pkg::rsp_t                 rsp,
  input  logic                           cfg_wr_en,
  input  logic [fdrq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdrq_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

  import fdrq_pkg::*;

  localparam int DET_AW    = (DETECTORS > 1) ? $clog2(DETECTORS) : 1;
  localparam int REP_AW    = (REPEATERS > 1) ? $clog2(REPEATERS) : 1;
  localparam int CLR_DEPTH = (DETECTORS > REPEATERS) ? DETECTORS : REPEATERS;
  localparam int CLR_AW    = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int DET_W     = $bits(det_entry_t);
  localparam int REP_W     = $bits(rep_entry_t);
  localparam int IDX_W     = 18;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_REP,
    S_DET
  } state_t;

  state_t            state;
  req_t              item;
  logic [DET_AW-1:0] det_idx;
  logic [CLR_AW-1:0] clr_addr;
  logic [15:0]       rep_confirm;
  det_cfg_t          det_cfg;

  logic              rep_we;
  logic [REP_AW-1:0] rep_wr_addr;
  logic [REP_W-1:0]  rep_wr_data;
  logic              rep_rd_en;
  logic [REP_AW-1:0] rep_rd_addr;
  logic [REP_W-1:0]  rep_rd_data;

  logic              det_we;
  logic [DET_AW-1:0] det_wr_addr;
  logic [DET_W-1:0]  det_wr_data;
  logic              det_rd_en;
  logic [DET_AW-1:0] det_rd_addr;
  logic [DET_W-1:0]  det_rd_data;

  rep_entry_t        rep_cur;
  rep_entry_t        rep_upd;
  logic [15:0]       rep_value;
  logic [15:0]       masked_status;
  logic [15:0]       change_next;
  det_entry_t        det_cur;
  det_entry_t        det_upd;
  logic [7:0]        det_value;
  logic              rep_ok;
  logic              rep_action;
  logic              base_hit;
  logic [IDX_W-1:0]  idx_full;
  logic              idx_ok;
  logic              slot_free;
  logic              rsp_load;
  rsp_t              rep_rsp;
  rsp_t              det_rsp;

  fdrq_ram #(
    .WIDTH (REP_W),
    .DEPTH (REPEATERS)
  ) u_rep_ram (
    .clk     (clk),
    .we      (rep_we),
    .wr_addr (rep_wr_addr),
    .wr_data (rep_wr_data),
    .rd_en   (rep_rd_en),
    .rd_addr (rep_rd_addr),
    .rd_data (rep_rd_data)
  );

  fdrq_ram #(
    .WIDTH (DET_W),
    .DEPTH (DETECTORS)
  ) u_det_ram (
    .clk     (clk),
    .we      (det_we),
    .wr_addr (det_wr_addr),
    .wr_data (det_wr_data),
    .rd_en   (det_rd_en),
    .rd_addr (det_rd_addr),
    .rd_data (det_rd_data)
  );

  assign det_cur = det_entry_t'(det_rd_data);

  fdrq_det_logic u_det_logic (
    .cur   (det_cur),
    .cfg   (det_cfg),
    .item  (item),
    .upd   (det_upd),
    .value (det_value)
  );

  assign req_ready  = (state == S_IDLE);
  assign slot_free  = !rsp_valid || rsp_ready;
  assign rep_cur    = rep_entry_t'(rep_rd_data);
  assign rep_ok     = 32'(item.repeater_addr) < REPEATERS;
  assign rep_action = (item.action == ACT_REP_REPORT) || (item.action == ACT_REP_START);

  // Detector index from the repeater's first table slot
  assign base_hit = 32'(rep_cur.first_slot) > INDEX_BASE;
  assign idx_full = base_hit ? (IDX_W'(rep_cur.first_slot) - IDX_W'(INDEX_BASE)
                                + IDX_W'(item.detector_addr) - IDX_W'(1)) : '0;
  assign idx_ok   = 32'(idx_full) < DETECTORS;

  // A new result enters the output register this cycle
  assign rsp_load = slot_free && (((state == S_REP) && !(rep_ok && !rep_action && idx_ok))
                                  || (state == S_DET));

  // Repeater entry update
  assign masked_status = rep_cur.status & STATUS_MASK;
  assign change_next   = rep_cur.change_hits + 16'd1;

  always_comb begin
    rep_upd   = rep_cur;
    rep_value = '0;
    if (item.action == ACT_REP_START) begin
      rep_upd.first_slot = item.start_address;
    end else begin
      rep_upd.status = masked_status;
      if (masked_status != item.repeater_data) begin
        rep_upd.change_hits = change_next;
        if (change_next >= rep_confirm) begin
          rep_upd.status = item.repeater_data;
          rep_value      = item.repeater_data;
        end
      end else begin
        rep_upd.change_hits = '0;
        rep_value           = masked_status;
      end
    end
  end

  always_comb begin
    rep_rsp              = '0;
    rep_rsp.result_value = (rep_ok && rep_action) ? rep_value : '0;
    det_rsp.result_value = 16'(det_value);
    det_rsp.index_valid  = 1'b1;
    det_rsp.pre_fire     = det_upd.pre_fire;
    det_rsp.real_fire    = det_upd.real_fire;
    det_rsp.led_on       = det_upd.led;
    det_rsp.offline      = det_upd.offline;
  end

  // Memory ports; each transaction writes back before the next one reads, so no forwarding
  always_comb begin
    rep_rd_en   = req_valid && req_ready;
    rep_rd_addr = REP_AW'(req.repeater_addr);
    det_rd_en   = (state == S_REP) && rep_ok && !rep_action && idx_ok;
    det_rd_addr = DET_AW'(idx_full);

    rep_we      = 1'b0;
    rep_wr_addr = REP_AW'(item.repeater_addr);
    rep_wr_data = REP_W'(rep_upd);
    det_we      = 1'b0;
    det_wr_addr = det_idx;
    det_wr_data = DET_W'(det_upd);

    case (state)
      S_CLEAR: begin
        rep_we      = 32'(clr_addr) < REPEATERS;
        rep_wr_addr = REP_AW'(clr_addr);
        rep_wr_data = '0;
        det_we      = 32'(clr_addr) < DETECTORS;
        det_wr_addr = DET_AW'(clr_addr);
        det_wr_data = '0;
      end
      S_REP: begin
        rep_we = slot_free && rep_ok && rep_action;
      end
      S_DET: begin
        det_we = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      rsp_valid   <= 1'b0;
      rep_confirm <= RST_REP_CONFIRM;
      det_cfg     <= '{offline_limit:     RST_OFFLINE_LIM,
                       real_fire_confirm: RST_REAL_CONFIRM,
                       pre_fire_confirm:  RST_PRE_CONFIRM};
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_REP_CONFIRM:  rep_confirm               <= cfg_wr_data;
          CFG_OFFLINE_LIM:  det_cfg.offline_limit     <= cfg_wr_data[7:0];
          CFG_REAL_CONFIRM: det_cfg.real_fire_confirm <= cfg_wr_data[7:0];
          CFG_PRE_CONFIRM:  det_cfg.pre_fire_confirm  <= cfg_wr_data[7:0];
          default: begin
          end
        endcase
      end

      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (32'(clr_addr) == CLR_DEPTH - 1) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            state <= S_REP;
          end
        end
        S_REP: begin
          if (rep_ok && !rep_action && idx_ok) begin
            det_idx <= DET_AW'(idx_full);
            state   <= S_DET;
          end else if (slot_free) begin
            rsp_valid <= 1'b1;
            rsp       <= rep_rsp;
            state     <= S_IDLE;
          end
        end
        S_DET: begin
          // hold write-back and result until the result register frees up
          if (slot_free) begin
            rsp_valid <= 1'b1;
            rsp       <= det_rsp;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_det_write_phase: assert property (@(posedge clk) disable iff (rst)
    det_we |-> (state == S_CLEAR) || (state == S_DET))
    else $error("detector table written outside clear or write-back");

  a_det_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DET) |-> (32'(det_idx) < DETECTORS))
    else $error("detector index out of table range");

  a_rep_result: assert property (@(posedge clk) disable iff (rst)
    (rep_we && (state == S_REP)) |=> rsp_valid && (state == S_IDLE))
    else $error("repeater write-back without result");

  a_no_index_no_flags: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.index_valid) |->
      !rsp.pre_fire && !rsp.real_fire && !rsp.led_on && !rsp.offline)
    else $error("flags reported without a detector index");

  a_real_implies_led: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.real_fire) |-> rsp.led_on)
    else $error("real fire latched without indicator");

endmodule

`default_nettype wire

// ===== sv/fdrq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/fdrq_det_logic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdrq_det_logic (
  input  fdrq_pkg::det_entry_t cur,
  input  fdrq_pkg::det_cfg_t   cfg,
  input  fdrq_pkg::req_t       item,
  output fdrq_pkg::det_entry_t upd,
  output logic [7:0]           value
);

  import fdrq_pkg::*;

  logic [7:0] type_min;
  logic [7:0] type_max;
  logic [7:0] data;
  logic [7:0] hits;
  logic       limits_ok;

  assign data      = item.detector_data;
  assign type_min  = cur.smoke ? SMOKE_MIN : HEAT_MIN;
  assign type_max  = cur.smoke ? SMOKE_MAX : HEAT_MAX;
  assign limits_ok = (cur.real_limit > type_min) && (cur.pre_limit > type_min);

  always_comb begin
    upd   = cur;
    value = '0;
    hits  = '0;
    if (item.action == ACT_DET_SETTINGS) begin
      upd.pre_limit  = item.pre_threshold;
      upd.real_limit = item.real_threshold;
      upd.smoke      = item.smoke_type;
      upd.stop       = item.comm_stop;
      upd.pre_fire   = 1'b0;
      upd.real_fire  = 1'b0;
      upd.led        = 1'b0;
    end else if (data == SILENT_VALUE) begin
      hits = cur.silent_hits + 8'd1;
      if (hits > cfg.offline_limit) begin
        upd.silent_hits = '0;
        upd.offline     = 1'b1;
      end else begin
        upd.silent_hits = hits;
      end
      upd.reading = '0;
    end else begin
      upd.offline = 1'b0;
      upd.reading = data;
      value       = data;
      if (!cur.stop && !cur.real_fire) begin
        // limits too low for the type: fall back to defaults, skip threshold checks for this reading
        if (!limits_ok) begin
          upd.pre_limit  = cur.smoke ? SMOKE_PRE_DEF : HEAT_PRE_DEF;
          upd.real_limit = cur.smoke ? SMOKE_REAL_DEF : HEAT_REAL_DEF;
        end
        if (data > type_max) begin
          // out of range for the type: keep the previous reading
          upd.reading = cur.reading;
          value       = cur.reading;
        end else if (limits_ok) begin
          if (data >= cur.real_limit) begin
            hits = cur.real_hits + 8'd1;
            if (hits >= cfg.real_fire_confirm) begin
              upd.real_hits = cfg.real_fire_confirm;
              upd.real_fire = 1'b1;
              upd.led       = 1'b1;
            end else begin
              upd.real_hits = hits;
            end
          end else begin
            upd.real_hits = '0;
            if (data >= cur.pre_limit) begin
              hits = cur.pre_hits + 8'd1;
              if (hits >= cfg.pre_fire_confirm) begin
                upd.pre_hits = cfg.pre_fire_confirm;
                upd.pre_fire = 1'b1;
                upd.led      = 1'b1;
              end else begin
                upd.pre_hits = hits;
              end
            end else begin
              upd.pre_hits = '0;
              upd.pre_fire = 1'b0;
              upd.led      = 1'b0;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
